FILE: hw/rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// shared types, constants and rom functions for the three-voice synth
// ----------------------------------------------------------------------------
`default_nettype none
package tvs_pkg;
   localparam int VoiceCount = 3;
   localparam int RegCount = 32;
   localparam logic [31:0] EnvTop = 32'hFF000000;
   localparam logic [31:0] HalfTurn = 32'h80000000;
   localparam logic [15:0] LfsrSeed = 16'hACE1;
   localparam logic [28:0] PhaseK = 29'd374823548;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_TICK = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ENV_IDLE = 3'd0,
      ENV_ATTACK = 3'd1,
      ENV_DECAY = 3'd2,
      ENV_SUSTAIN = 3'd3,
      ENV_RELEASE = 3'd4
   } env_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREQ,
      ST_VOICE,
      ST_SCALE,
      ST_OUT
   } state_type;

   // operation for the shared multiplier
   typedef struct packed {
      logic [16:0] a;
      logic [28:0] b;
   } mul_req_type;

   function automatic logic [31:0] attack_rom(input logic [3:0] idx);
      logic [31:0] r;
      case (idx)
         4'd0: r = 32'd48505556;
         4'd1: r = 32'd12126389;
         4'd2: r = 32'd6063194;
         4'd3: r = 32'd4042129;
         4'd4: r = 32'd2552924;
         4'd5: r = 32'd1732341;
         4'd6: r = 32'd1426634;
         4'd7: r = 32'd1212638;
         4'd8: r = 32'd970111;
         4'd9: r = 32'd388044;
         4'd10: r = 32'd194022;
         4'd11: r = 32'd121263;
         4'd12: r = 32'd97011;
         4'd13: r = 32'd32337;
         4'd14: r = 32'd19402;
         default: r = 32'd12126;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] decay_rom(input logic [3:0] idx);
      logic [31:0] r;
      case (idx)
         4'd0: r = 32'd16168518;
         4'd1: r = 32'd4042129;
         4'd2: r = 32'd2021064;
         4'd3: r = 32'd1347376;
         4'd4: r = 32'd850974;
         4'd5: r = 32'd577447;
         4'd6: r = 32'd475544;
         4'd7: r = 32'd404212;
         4'd8: r = 32'd323370;
         4'd9: r = 32'd129348;
         4'd10: r = 32'd64674;
         4'd11: r = 32'd40421;
         4'd12: r = 32'd32337;
         4'd13: r = 32'd10779;
         4'd14: r = 32'd6467;
         default: r = 32'd4042;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/tvs_mul.sv
// ----------------------------------------------------------------------------
// tvs_mul
// shared registered multiplier, 17 x 29 bits
// ----------------------------------------------------------------------------
`default_nettype none
module tvs_mul (
   input  wire logic                clock,
   input  tvs_pkg::mul_req_type     req,
   output logic [45:0]              prod
);
   logic [45:0] prod_ff;
   always_ff @(posedge clock) begin
      prod_ff <= 46'(req.a) * 46'(req.b);
   end
   assign prod = prod_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/three_voice_synth_adsr.sv
// ----------------------------------------------------------------------------
// three_voice_synth_adsr
// three-voice dds oscillator and adsr envelope sound generator
// ----------------------------------------------------------------------------
// Each request transaction is a register write (cmd 0), a sample tick (cmd 1)
// or a full sound reset (cmd 2); only a tick produces a response transaction
// carrying one unsigned 8-bit audio sample. The block handles one transaction
// at a time under a small sequencer around one shared 17x29 multiplier. A write
// that touches a frequency register also makes one multiplier pass for the
// phase step. A tick steps the voices and passes wave times level through the
// multiplier, then feeds the volume scale, then loads the output register.
// While an earlier sample still waits in the output register, writes keep
// flowing, but a new tick holds in its last step until the register frees. A
// reset command clears all voice state. cmd 3 is accepted and ignored.
`default_nettype none
module three_voice_synth_adsr (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [4:0] req_reg_index,
   input  wire logic [7:0] req_reg_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_audio_sample
);
   localparam int Vc = tvs_pkg::VoiceCount;

   // copies of the bytes that the voices read every tick
   logic [15:0] freq_ff [Vc];
   logic [11:0] pw_ff [Vc];
   logic [7:0] ctrl_ff [Vc];
   logic [7:0] ad_ff [Vc];
   logic [7:0] sr_ff [Vc];
   logic [3:0] vol_ff;

   logic [31:0] phase_ff [Vc];
   logic [31:0] pstep_ff [Vc];
   logic [31:0] env_ff [Vc];
   logic [31:0] astep_ff [Vc];
   logic [31:0] dstep_ff [Vc];
   logic [31:0] rstep_ff [Vc];
   logic [7:0] sus_ff [Vc];
   tvs_pkg::env_type eph_ff [Vc];
   logic gate_ff [Vc];
   logic [15:0] lfsr_ff [Vc];
   logic nclk_ff [Vc];

   tvs_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff;         // voice / pipeline step
   logic [1:0] fvoice_ff;      // voice whose phase step is being refreshed
   logic [9:0] mix_ff;         // sum of three voice products, at most 762
   logic [7:0] sample_ff;
   logic rsp_valid_ff;

   tvs_pkg::mul_req_type mreq;
   logic [45:0] prod;

   tvs_mul u_mul (.clock(clock), .req(mreq), .prod(prod));

   // voice under work in the tick pass
   logic [1:0] cv;
   assign cv = (cnt_ff < 5'(Vc)) ? cnt_ff[1:0] : 2'd0;

   // waveform and envelope step for the current voice
   logic [31:0] ph_new;
   logic [7:0] wave;
   logic clk27, lfsr_shift;
   logic [15:0] lfsr_new;
   logic [31:0] env_new;
   tvs_pkg::env_type eph_new;
   logic [32:0] asum;

   always_comb begin
      ph_new = phase_ff[cv] + pstep_ff[cv];
      clk27 = ph_new[27];
      lfsr_shift = clk27 && !nclk_ff[cv];
      lfsr_new = lfsr_ff[cv];
      if (lfsr_shift) begin
         lfsr_new = {lfsr_ff[cv][0] ^ lfsr_ff[cv][2] ^ lfsr_ff[cv][3] ^ lfsr_ff[cv][5],
                     lfsr_ff[cv][15:1]};
      end
      // noise, then pulse, then sawtooth, then triangle
      if (ctrl_ff[cv][7]) begin
         wave = lfsr_new[15:8];
      end else if (ctrl_ff[cv][6]) begin
         wave = (ph_new[31:20] < pw_ff[cv]) ? 8'hFF : 8'h00;
      end else if (ctrl_ff[cv][5]) begin
         wave = ph_new[31:24];
      end else if (ctrl_ff[cv][4]) begin
         wave = (ph_new < tvs_pkg::HalfTurn) ? ph_new[30:23] : ~ph_new[30:23];
      end else begin
         wave = 8'd0;
      end

      env_new = env_ff[cv];
      eph_new = eph_ff[cv];
      asum = 33'(env_ff[cv]) + 33'(astep_ff[cv]);
      case (eph_ff[cv])
         tvs_pkg::ENV_ATTACK: begin
            if (asum[32] || asum[31:0] >= tvs_pkg::EnvTop) begin
               env_new = tvs_pkg::EnvTop;
               eph_new = (sus_ff[cv] != 8'hFF) ? tvs_pkg::ENV_DECAY : tvs_pkg::ENV_SUSTAIN;
            end else begin
               env_new = asum[31:0];
            end
         end
         tvs_pkg::ENV_DECAY: begin
            if (env_ff[cv] <= dstep_ff[cv] || env_ff[cv][31:24] <= sus_ff[cv]) begin
               env_new = {sus_ff[cv], 24'd0};
               eph_new = tvs_pkg::ENV_SUSTAIN;
            end else begin
               env_new = env_ff[cv] - dstep_ff[cv];
            end
         end
         tvs_pkg::ENV_SUSTAIN: env_new = {sus_ff[cv], 24'd0};
         tvs_pkg::ENV_RELEASE: begin
            if (env_ff[cv] <= rstep_ff[cv]) begin
               env_new = 32'd0;
               eph_new = tvs_pkg::ENV_IDLE;
            end else begin
               env_new = env_ff[cv] - rstep_ff[cv];
            end
         end
         default: ;
      endcase
   end

   // volume divide by 45: reciprocal 1456/65536 is never above the true
   // quotient and at most one below, so one correction step is enough
   logic [13:0] scaled;
   logic [7:0] q0;
   logic [13:0] rem;
   logic out_free;
   assign scaled = 14'(mix_ff) * 14'(vol_ff);
   // output register is empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // request decode
   logic req_fire;
   logic [2:0] wvoice;
   logic [2:0] wreg;
   tvs_pkg::cmd_type cmd;
   assign req_fire = req_valid && req_ready;
   assign cmd = tvs_pkg::cmd_type'(req_cmd);
   always_comb begin
      wvoice = 3'd3;
      wreg = 3'd0;
      for (int v = 0; v < Vc; v++) begin
         if (req_reg_index >= 5'(7 * v) && req_reg_index < 5'(7 * v + 7)) begin
            wvoice = 3'(v);
            wreg = 3'(req_reg_index - 5'(7 * v));
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mreq = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tvs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               unique case (cmd)
                  tvs_pkg::CMD_WRITE: begin
                     if (wvoice != 3'd3 && (wreg == 3'd0 || wreg == 3'd1)) begin
                        state_in = tvs_pkg::ST_FREQ;
                     end
                  end
                  tvs_pkg::CMD_TICK: state_in = tvs_pkg::ST_VOICE;
                  default: ;
               endcase
            end
         end
         tvs_pkg::ST_FREQ: begin
            mreq.a = {1'b0, freq_ff[fvoice_ff]};
            mreq.b = tvs_pkg::PhaseK;
            if (cnt_ff == 5'd1) state_in = tvs_pkg::ST_IDLE;
         end
         tvs_pkg::ST_VOICE: begin
            mreq.a = {9'd0, wave};
            mreq.b = 29'(env_new[31:24]);
            if (cnt_ff == 5'(Vc)) state_in = tvs_pkg::ST_SCALE;
         end
         tvs_pkg::ST_SCALE: begin
            mreq.a = {3'd0, scaled};
            mreq.b = 29'd1456;
            state_in = tvs_pkg::ST_OUT;
         end
         tvs_pkg::ST_OUT: begin
            // keep the scale product steady while the output register is busy
            mreq.a = {3'd0, scaled};
            mreq.b = 29'd1456;
            if (out_free) state_in = tvs_pkg::ST_IDLE;
         end
         default: state_in = tvs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q0 = prod[23:16];
      rem = scaled - 14'(q0) * 14'd45;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvs_pkg::ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) cnt_ff <= '0;
         else cnt_ff <= cnt_ff + 5'd1;
         if (state_ff == tvs_pkg::ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // voice state
   always_ff @(posedge clock) begin
      if (reset || (req_fire && cmd == tvs_pkg::CMD_RESET)) begin
         vol_ff <= '0;
         mix_ff <= '0;
         for (int v = 0; v < Vc; v++) begin
            freq_ff[v] <= '0;
            pw_ff[v] <= '0;
            ctrl_ff[v] <= '0;
            ad_ff[v] <= '0;
            sr_ff[v] <= '0;
            phase_ff[v] <= '0;
            pstep_ff[v] <= '0;
            env_ff[v] <= '0;
            astep_ff[v] <= '0;
            dstep_ff[v] <= '0;
            rstep_ff[v] <= '0;
            sus_ff[v] <= '0;
            eph_ff[v] <= tvs_pkg::ENV_IDLE;
            gate_ff[v] <= 1'b0;
            lfsr_ff[v] <= tvs_pkg::LfsrSeed;
            nclk_ff[v] <= 1'b0;
         end
      end else begin
         if (req_fire && cmd == tvs_pkg::CMD_WRITE) begin
            if (req_reg_index == 5'd24) vol_ff <= req_reg_value[3:0];
            if (wvoice != 3'd3) begin
               fvoice_ff <= wvoice[1:0];
               unique case (wreg)
                  3'd0: freq_ff[wvoice[1:0]][7:0] <= req_reg_value;
                  3'd1: freq_ff[wvoice[1:0]][15:8] <= req_reg_value;
                  3'd2: pw_ff[wvoice[1:0]][7:0] <= req_reg_value;
                  3'd3: pw_ff[wvoice[1:0]][11:8] <= req_reg_value[3:0];
                  3'd4: begin
                     ctrl_ff[wvoice[1:0]] <= req_reg_value;
                     if (req_reg_value[0] && !gate_ff[wvoice[1:0]]) begin
                        phase_ff[wvoice[1:0]] <= '0;
                        env_ff[wvoice[1:0]] <= '0;
                        eph_ff[wvoice[1:0]] <= tvs_pkg::ENV_ATTACK;
                     end else if (!req_reg_value[0] && gate_ff[wvoice[1:0]]) begin
                        eph_ff[wvoice[1:0]] <= tvs_pkg::ENV_RELEASE;
                     end
                     gate_ff[wvoice[1:0]] <= req_reg_value[0];
                  end
                  // either envelope byte refreshes all four envelope settings
                  3'd5: begin
                     ad_ff[wvoice[1:0]] <= req_reg_value;
                     astep_ff[wvoice[1:0]] <= tvs_pkg::attack_rom(req_reg_value[7:4]);
                     dstep_ff[wvoice[1:0]] <= tvs_pkg::decay_rom(req_reg_value[3:0]);
                     rstep_ff[wvoice[1:0]] <= tvs_pkg::decay_rom(sr_ff[wvoice[1:0]][3:0]);
                     sus_ff[wvoice[1:0]] <= 8'(sr_ff[wvoice[1:0]][7:4]) * 8'd17;
                  end
                  3'd6: begin
                     sr_ff[wvoice[1:0]] <= req_reg_value;
                     astep_ff[wvoice[1:0]] <= tvs_pkg::attack_rom(ad_ff[wvoice[1:0]][7:4]);
                     dstep_ff[wvoice[1:0]] <= tvs_pkg::decay_rom(ad_ff[wvoice[1:0]][3:0]);
                     rstep_ff[wvoice[1:0]] <= tvs_pkg::decay_rom(req_reg_value[3:0]);
                     sus_ff[wvoice[1:0]] <= 8'(req_reg_value[7:4]) * 8'd17;
                  end
                  default: ;
               endcase
            end
         end
         if (state_ff == tvs_pkg::ST_FREQ && cnt_ff == 5'd1) begin
            pstep_ff[fvoice_ff] <= {2'b00, prod[45:16]};
         end
         if (req_fire && cmd == tvs_pkg::CMD_TICK) mix_ff <= '0;
         if (state_ff == tvs_pkg::ST_VOICE) begin
            if (cnt_ff < 5'(Vc)) begin
               phase_ff[cv] <= ph_new;
               env_ff[cv] <= env_new;
               eph_ff[cv] <= eph_new;
               if (ctrl_ff[cv][7]) begin
                  lfsr_ff[cv] <= lfsr_new;
                  nclk_ff[cv] <= clk27;
               end
            end
            // add the registered product of the previous voice
            if (cnt_ff != 5'd0) mix_ff <= mix_ff + 10'(prod[15:8]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tvs_pkg::ST_OUT && out_free) begin
         sample_ff <= (rem >= 14'd45) ? q0 + 8'd1 : q0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_audio_sample = sample_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/tvs_checker.sv
// ----------------------------------------------------------------------------
// tvs_checker
// port-level checks for the three-voice synth
// ----------------------------------------------------------------------------
`default_nettype none
module tvs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_audio_sample
);
   a_no_rsp_without_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != tvs_pkg::CMD_TICK && !rsp_valid |=> !rsp_valid)
      else $error("response without a tick");
   a_busy_after_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == tvs_pkg::CMD_TICK |=> !req_ready)
      else $error("ready during tick");
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake unknown");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_audio_sample))
      else $error("response dropped");
endmodule

bind three_voice_synth_adsr tvs_checker u_tvs_checker (.*);
`default_nettype wire
